/* src/ioll_pkg.sv */
// Package for the indexed ordered list: operation and status codes, request
// and result structs shared by the list stages. No dependencies.
`default_nettype none

package ioll_pkg;

  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_GET      = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_INS_TAIL = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_t                 status;
  } res_t;

endpackage

`default_nettype wire

/* src/indexed_ordered_list_top.sv */
// Indexed ordered list top level: input register, slot store, result register.
// Depends on ioll_pkg, ioll_in_stage, ioll_store, ioll_out_stage.
// out_valid is set through the input register and then the result register; one item per cycle.
// busy is never raised; all slots shift in parallel, so nothing limits rate.
// Synchronous reset empties the list; slot contents are not cleared.
// The receiver cannot stall: out_valid lasts exactly one cycle per item.
`default_nettype none

module indexed_ordered_list_top
  import ioll_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_op,
  input  wire logic [POS_W-1:0]        in_position,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  output logic                         out_valid,
  output logic signed [VAL_W-1:0]      out_read_value,
  output logic [1:0]                   out_status
);

  req_t req_in;
  req_t req;
  logic req_valid;
  logic accept;
  res_t res;
  res_t res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign req_in.op         = op_t'(in_op);
  assign req_in.position   = in_position;
  assign req_in.item_value = in_item_value;

  ioll_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_in    (req_in),
    .req_valid (req_valid),
    .req_out   (req)
  );

  ioll_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .res       (res)
  );

  ioll_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (req_valid),
    .res_in    (res),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_read_value = res_q.read_value;
  assign out_status     = res_q.status;

endmodule

`default_nettype wire

/* src/ioll_in_stage.sv */
// Input register of the indexed ordered list: captures one item per cycle.
// Depends on ioll_pkg.
`default_nettype none

module ioll_in_stage
  import ioll_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire req_t  req_in,
  output logic       req_valid,
  output req_t       req_out
);

  logic req_valid_r;
  req_t req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_in;
    end
  end

  assign req_valid = req_valid_r;
  assign req_out   = req_r;

endmodule

`default_nettype wire

/* src/ioll_store.sv */
// Slot array and length of the indexed ordered list; executes one registered
// item per cycle, shifting all slots in parallel. Depends on ioll_pkg.
`default_nettype none

module ioll_store
  import ioll_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic req_valid,
  input  wire req_t req,
  output res_t      res
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  logic signed [VAL_W-1:0] slot_r   [CAPACITY];
  logic signed [VAL_W-1:0] slot_nxt [CAPACITY];
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        len_nxt;
  logic                    full;
  logic                    hit;
  logic                    do_head;
  logic                    do_tail;
  logic                    do_remove;

  assign full      = (len_r == LEN_W'(CAPACITY));
  assign hit       = (CMP_W'(req.position) < CMP_W'(len_r));
  assign do_head   = (req.op == OP_INS_HEAD) && !full;
  assign do_tail   = (req.op == OP_INS_TAIL) && !full;
  assign do_remove = (req.op == OP_REMOVE) && hit;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic signed [VAL_W-1:0] head_src;
    logic signed [VAL_W-1:0] rem_src;

    if (g == 0) begin : g_first
      assign head_src = req.item_value;
    end else begin : g_rest
      assign head_src = slot_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rem_src = slot_r[g];
    end else begin : g_inner
      assign rem_src = (CMP_W'(g) >= CMP_W'(req.position)) ? slot_r[g+1] : slot_r[g];
    end

    always_comb begin
      slot_nxt[g] = slot_r[g];
      if (do_head) begin
        slot_nxt[g] = head_src;
      end else if (do_tail && (LEN_W'(g) == len_r)) begin
        slot_nxt[g] = req.item_value;
      end else if (do_remove) begin
        slot_nxt[g] = rem_src;
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (do_head || do_tail) begin
      len_nxt = len_r + LEN_W'(1);
    end else if (do_remove) begin
      len_nxt = len_r - LEN_W'(1);
    end
  end

  always_comb begin
    res.read_value = NONE_VALUE;
    res.status     = ST_OK;
    case (req.op)
      OP_GET: begin
        if (hit) begin
          res.read_value = slot_r[req.position[IDX_W-1:0]];
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (full) begin
          res.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          res.status = ST_ABSENT;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (req_valid) begin
      len_r <= len_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !req_valid |=> $stable(len_r))
    else $error("length moved without an item");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && full && (req.op == OP_INS_HEAD || req.op == OP_INS_TAIL)
      |=> len_r == LEN_W'(CAPACITY))
    else $error("insert into full list changed length");

  a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && do_remove |=> len_r == $past(len_r) - LEN_W'(1))
    else $error("remove did not shorten list");

endmodule

`default_nettype wire

/* src/ioll_out_stage.sv */
// Result register of the indexed ordered list: one-cycle strobe with the
// result of each executed item. Depends on ioll_pkg.
`default_nettype none

module ioll_out_stage
  import ioll_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  wire res_t res_in,
  output logic      out_valid,
  output res_t      res_out
);

  logic out_valid_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire
